/* rtl/eight_bit_cpu_alu_execute_core_defines.svh */
// Assertion macros used by the execute core RTL.
`ifndef EIGHT_BIT_CPU_ALU_EXECUTE_CORE_DEFINES_SVH
`define EIGHT_BIT_CPU_ALU_EXECUTE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define EBC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define EBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ebc_pkg.sv */
// Shared types, operation codes and constants of the execute core.
package ebc_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [7:0] STACK_PAGE_HI = 8'h01;
   localparam logic [7:0] SP_RESET      = 8'hFF;

   // Request operation codes
   localparam logic [5:0] CMD_LDA     = 6'd0;
   localparam logic [5:0] CMD_LDX     = 6'd1;
   localparam logic [5:0] CMD_LDY     = 6'd2;
   localparam logic [5:0] CMD_ADC     = 6'd3;
   localparam logic [5:0] CMD_SBC     = 6'd4;
   localparam logic [5:0] CMD_AND     = 6'd5;
   localparam logic [5:0] CMD_ORA     = 6'd6;
   localparam logic [5:0] CMD_EOR     = 6'd7;
   localparam logic [5:0] CMD_TAX     = 6'd8;
   localparam logic [5:0] CMD_TAY     = 6'd9;
   localparam logic [5:0] CMD_TSX     = 6'd10;
   localparam logic [5:0] CMD_TXA     = 6'd11;
   localparam logic [5:0] CMD_TYA     = 6'd12;
   localparam logic [5:0] CMD_TXS     = 6'd13;
   localparam logic [5:0] CMD_INX     = 6'd14;
   localparam logic [5:0] CMD_INY     = 6'd15;
   localparam logic [5:0] CMD_DEX     = 6'd16;
   localparam logic [5:0] CMD_DEY     = 6'd17;
   localparam logic [5:0] CMD_ASL_A   = 6'd18;
   localparam logic [5:0] CMD_LSR_A   = 6'd19;
   localparam logic [5:0] CMD_ROL_A   = 6'd20;
   localparam logic [5:0] CMD_ROR_A   = 6'd21;
   localparam logic [5:0] CMD_ASL_M   = 6'd22;
   localparam logic [5:0] CMD_LSR_M   = 6'd23;
   localparam logic [5:0] CMD_ROL_M   = 6'd24;
   localparam logic [5:0] CMD_ROR_M   = 6'd25;
   localparam logic [5:0] CMD_INC     = 6'd26;
   localparam logic [5:0] CMD_DEC     = 6'd27;
   localparam logic [5:0] CMD_CMP     = 6'd28;
   localparam logic [5:0] CMD_CPX     = 6'd29;
   localparam logic [5:0] CMD_CPY     = 6'd30;
   localparam logic [5:0] CMD_PHA     = 6'd31;
   localparam logic [5:0] CMD_PLA     = 6'd32;
   localparam logic [5:0] CMD_BIT     = 6'd33;
   localparam logic [5:0] CMD_CLC     = 6'd34;
   localparam logic [5:0] CMD_SEC     = 6'd35;
   localparam logic [5:0] CMD_NOP     = 6'd36;

   // ALU functions
   localparam logic [3:0] ALU_PASS = 4'd0;
   localparam logic [3:0] ALU_ADD  = 4'd1;
   localparam logic [3:0] ALU_SUB  = 4'd2;
   localparam logic [3:0] ALU_AND  = 4'd3;
   localparam logic [3:0] ALU_OR   = 4'd4;
   localparam logic [3:0] ALU_XOR  = 4'd5;
   localparam logic [3:0] ALU_INC  = 4'd6;
   localparam logic [3:0] ALU_DEC  = 4'd7;
   localparam logic [3:0] ALU_ASL  = 4'd8;
   localparam logic [3:0] ALU_LSR  = 4'd9;
   localparam logic [3:0] ALU_ROL  = 4'd10;
   localparam logic [3:0] ALU_ROR  = 4'd11;
   localparam logic [3:0] ALU_CMP  = 4'd12;
   localparam logic [3:0] ALU_BIT  = 4'd13;

   // ALU left operand source
   localparam logic [2:0] SRC_OPND = 3'd0;
   localparam logic [2:0] SRC_A    = 3'd1;
   localparam logic [2:0] SRC_X    = 3'd2;
   localparam logic [2:0] SRC_Y    = 3'd3;
   localparam logic [2:0] SRC_SP   = 3'd4;

   // ALU result destination
   localparam logic [2:0] DST_NONE = 3'd0;
   localparam logic [2:0] DST_A    = 3'd1;
   localparam logic [2:0] DST_X    = 3'd2;
   localparam logic [2:0] DST_Y    = 3'd3;
   localparam logic [2:0] DST_SP   = 3'd4;
   localparam logic [2:0] DST_MEM  = 3'd5;

   // Flag mask bits
   localparam int unsigned MSK_C = 0;
   localparam int unsigned MSK_Z = 1;
   localparam int unsigned MSK_N = 2;

   typedef struct packed {
      logic [5:0]  cmd;
      logic [7:0]  operand;
      logic [2:0]  flag_mask;
      logic [15:0] mem_addr;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_a;
      logic [7:0]  out_x;
      logic [7:0]  out_y;
      logic [7:0]  out_sp;
      logic        out_carry;
      logic        out_zero;
      logic        out_negative;
      logic        mem_write;
      logic [15:0] write_address;
      logic [7:0]  write_data;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  alu_op;
      logic [2:0]  src;
      logic [2:0]  dst;
      logic        carry_ok;
      logic        nz_ok;
      logic        set_carry;
      logic        clr_carry;
      logic        stack_push;
      logic        stack_pull;
      logic [7:0]  operand;
      logic [2:0]  flag_mask;
      logic [15:0] mem_addr;
   } dec_type;

endpackage

/* rtl/ebc_fifo.sv */
// Small register queue with push/full and pop/empty sides.
module ebc_fifo #(
   parameter type item_type = logic,
   parameter int unsigned Depth = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   item_type            store_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/ebc_front.sv */
// Front end: accept requests and decode them into ALU controls.
module ebc_front (
   input  logic             push,
   input  ebc_pkg::req_type req_item,
   output logic             full,
   output logic             dq_push,
   output ebc_pkg::dec_type dq_item,
   input  logic             dq_full
);
   import ebc_pkg::*;

   assign full    = dq_full;
   assign dq_push = push;

   always_comb begin
      dq_item            = '0;
      dq_item.alu_op     = ALU_PASS;
      dq_item.src        = SRC_OPND;
      dq_item.dst        = DST_NONE;
      dq_item.operand    = req_item.operand;
      dq_item.flag_mask  = req_item.flag_mask;
      dq_item.mem_addr   = req_item.mem_addr;
      unique case (req_item.cmd)
         CMD_LDA: begin dq_item.dst = DST_A; dq_item.nz_ok = 1'b1; end
         CMD_LDX: begin dq_item.dst = DST_X; dq_item.nz_ok = 1'b1; end
         CMD_LDY: begin dq_item.dst = DST_Y; dq_item.nz_ok = 1'b1; end
         CMD_ADC, CMD_SBC: begin
            dq_item.alu_op   = (req_item.cmd == CMD_ADC) ? ALU_ADD : ALU_SUB;
            dq_item.src      = SRC_A;
            dq_item.dst      = DST_A;
            dq_item.carry_ok = 1'b1;
            dq_item.nz_ok    = 1'b1;
         end
         CMD_AND: begin
            dq_item.alu_op = ALU_AND; dq_item.src = SRC_A;
            dq_item.dst = DST_A; dq_item.nz_ok = 1'b1;
         end
         CMD_ORA: begin
            dq_item.alu_op = ALU_OR; dq_item.src = SRC_A;
            dq_item.dst = DST_A; dq_item.nz_ok = 1'b1;
         end
         CMD_EOR: begin
            dq_item.alu_op = ALU_XOR; dq_item.src = SRC_A;
            dq_item.dst = DST_A; dq_item.nz_ok = 1'b1;
         end
         CMD_TAX: begin dq_item.src = SRC_A;  dq_item.dst = DST_X; dq_item.nz_ok = 1'b1; end
         CMD_TAY: begin dq_item.src = SRC_A;  dq_item.dst = DST_Y; dq_item.nz_ok = 1'b1; end
         CMD_TSX: begin dq_item.src = SRC_SP; dq_item.dst = DST_X; dq_item.nz_ok = 1'b1; end
         CMD_TXA: begin dq_item.src = SRC_X;  dq_item.dst = DST_A; dq_item.nz_ok = 1'b1; end
         CMD_TYA: begin dq_item.src = SRC_Y;  dq_item.dst = DST_A; dq_item.nz_ok = 1'b1; end
         CMD_TXS: begin dq_item.src = SRC_X;  dq_item.dst = DST_SP; end
         CMD_INX, CMD_DEX: begin
            dq_item.alu_op = (req_item.cmd == CMD_INX) ? ALU_INC : ALU_DEC;
            dq_item.src = SRC_X; dq_item.dst = DST_X; dq_item.nz_ok = 1'b1;
         end
         CMD_INY, CMD_DEY: begin
            dq_item.alu_op = (req_item.cmd == CMD_INY) ? ALU_INC : ALU_DEC;
            dq_item.src = SRC_Y; dq_item.dst = DST_Y; dq_item.nz_ok = 1'b1;
         end
         CMD_ASL_A, CMD_LSR_A, CMD_ROL_A, CMD_ROR_A: begin
            dq_item.alu_op   = ALU_ASL + 4'(req_item.cmd - CMD_ASL_A);
            dq_item.src      = SRC_A;
            dq_item.dst      = DST_A;
            dq_item.carry_ok = 1'b1;
            dq_item.nz_ok    = 1'b1;
         end
         CMD_ASL_M, CMD_LSR_M, CMD_ROL_M, CMD_ROR_M: begin
            dq_item.alu_op   = ALU_ASL + 4'(req_item.cmd - CMD_ASL_M);
            dq_item.dst      = DST_MEM;
            dq_item.carry_ok = 1'b1;
            dq_item.nz_ok    = 1'b1;
         end
         CMD_INC, CMD_DEC: begin
            dq_item.alu_op = (req_item.cmd == CMD_INC) ? ALU_INC : ALU_DEC;
            dq_item.dst    = DST_MEM;
            dq_item.nz_ok  = 1'b1;
         end
         CMD_CMP, CMD_CPX, CMD_CPY: begin
            dq_item.alu_op   = ALU_CMP;
            dq_item.src      = (req_item.cmd == CMD_CMP) ? SRC_A :
                               (req_item.cmd == CMD_CPX) ? SRC_X : SRC_Y;
            dq_item.carry_ok = 1'b1;
            dq_item.nz_ok    = 1'b1;
         end
         CMD_PHA: begin
            dq_item.src = SRC_A; dq_item.dst = DST_MEM; dq_item.stack_push = 1'b1;
         end
         CMD_PLA: begin
            dq_item.dst = DST_A; dq_item.nz_ok = 1'b1; dq_item.stack_pull = 1'b1;
         end
         CMD_BIT: begin
            dq_item.alu_op = ALU_BIT; dq_item.src = SRC_A; dq_item.nz_ok = 1'b1;
         end
         CMD_CLC: dq_item.clr_carry = 1'b1;
         CMD_SEC: dq_item.set_carry = 1'b1;
         default: dq_item.dst = DST_NONE;
      endcase
   end

endmodule

/* rtl/ebc_back.sv */
// Back end: architectural registers, ALU and result formation.
module ebc_back (
   input  logic             clock,
   input  logic             reset,
   input  ebc_pkg::dec_type dq_item,
   input  logic             dq_empty,
   output logic             dq_pop,
   output logic             rq_push,
   output ebc_pkg::rsp_type rq_item,
   input  logic             rq_full
);
   import ebc_pkg::*;

   logic [7:0] a_ff, a_in;
   logic [7:0] x_ff, x_in;
   logic [7:0] y_ff, y_in;
   logic [7:0] sp_ff, sp_in;
   logic       c_ff, c_in;
   logic       z_ff, z_in;
   logic       n_ff, n_in;

   logic       fire;
   logic [7:0] lhs, rhs, rhs_eff, res;
   logic [8:0] sum;
   logic       cin, cout, sub_mode, mem_wr, neg_val;

   assign fire    = !dq_empty && !rq_full;
   assign dq_pop  = fire;
   assign rq_push = fire;

   always_comb begin
      unique case (dq_item.src)
         SRC_A:   lhs = a_ff;
         SRC_X:   lhs = x_ff;
         SRC_Y:   lhs = y_ff;
         SRC_SP:  lhs = sp_ff;
         default: lhs = dq_item.operand;
      endcase
   end

   assign rhs      = dq_item.operand;
   assign sub_mode = (dq_item.alu_op == ALU_SUB) || (dq_item.alu_op == ALU_CMP);
   assign rhs_eff  = sub_mode ? ~rhs : rhs;
   assign cin      = (dq_item.alu_op == ALU_CMP) ? 1'b1 : c_ff;
   assign sum      = {1'b0, lhs} + {1'b0, rhs_eff} + {8'd0, cin};

   always_comb begin
      res  = lhs;
      cout = c_ff;
      unique case (dq_item.alu_op)
         ALU_ADD, ALU_SUB, ALU_CMP: begin res = sum[7:0]; cout = sum[8]; end
         ALU_AND: res = lhs & rhs;
         ALU_OR:  res = lhs | rhs;
         ALU_XOR: res = lhs ^ rhs;
         ALU_INC: res = lhs + 8'd1;
         ALU_DEC: res = lhs - 8'd1;
         ALU_ASL: begin res = {lhs[6:0], 1'b0}; cout = lhs[7]; end
         ALU_LSR: begin res = {1'b0, lhs[7:1]}; cout = lhs[0]; end
         ALU_ROL: begin res = {lhs[6:0], c_ff}; cout = lhs[7]; end
         ALU_ROR: begin res = {c_ff, lhs[7:1]}; cout = lhs[0]; end
         ALU_BIT: res = lhs & rhs;
         default: res = lhs;
      endcase
   end

   // BIT takes negative from the operand, not from the masked value
   assign neg_val = (dq_item.alu_op == ALU_BIT) ? rhs[7] : res[7];
   assign mem_wr  = (dq_item.dst == DST_MEM);

   always_comb begin
      a_in  = (dq_item.dst == DST_A) ? res : a_ff;
      x_in  = (dq_item.dst == DST_X) ? res : x_ff;
      y_in  = (dq_item.dst == DST_Y) ? res : y_ff;
      if (dq_item.stack_push) begin
         sp_in = sp_ff - 8'd1;
      end else if (dq_item.stack_pull) begin
         sp_in = sp_ff + 8'd1;
      end else if (dq_item.dst == DST_SP) begin
         sp_in = res;
      end else begin
         sp_in = sp_ff;
      end
      priority if (dq_item.clr_carry) begin
         c_in = 1'b0;
      end else if (dq_item.set_carry) begin
         c_in = 1'b1;
      end else if (dq_item.carry_ok && dq_item.flag_mask[MSK_C]) begin
         c_in = cout;
      end else begin
         c_in = c_ff;
      end
      z_in = (dq_item.nz_ok && dq_item.flag_mask[MSK_Z]) ? (res == 8'd0) : z_ff;
      n_in = (dq_item.nz_ok && dq_item.flag_mask[MSK_N]) ? neg_val : n_ff;
   end

   always_comb begin
      rq_item.out_a        = a_in;
      rq_item.out_x        = x_in;
      rq_item.out_y        = y_in;
      rq_item.out_sp       = sp_in;
      rq_item.out_carry    = c_in;
      rq_item.out_zero     = z_in;
      rq_item.out_negative = n_in;
      rq_item.mem_write    = mem_wr;
      rq_item.write_data   = mem_wr ? res : 8'd0;
      if (!mem_wr) begin
         rq_item.write_address = 16'd0;
      end else if (dq_item.stack_push) begin
         rq_item.write_address = {STACK_PAGE_HI, sp_ff};
      end else begin
         rq_item.write_address = dq_item.mem_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff  <= 8'd0;
         x_ff  <= 8'd0;
         y_ff  <= 8'd0;
         sp_ff <= SP_RESET;
         c_ff  <= 1'b0;
         z_ff  <= 1'b0;
         n_ff  <= 1'b0;
      end else if (fire) begin
         a_ff  <= a_in;
         x_ff  <= x_in;
         y_ff  <= y_in;
         sp_ff <= sp_in;
         c_ff  <= c_in;
         z_ff  <= z_in;
         n_ff  <= n_in;
      end
   end

endmodule

/* rtl/eight_bit_cpu_alu_execute_core.sv */
// A request is held in the decode queue, executed, then held in the result queue until popped.
// Throughput: one request per cycle while the queues have room; execute retires one per cycle.
// The decode queue and the result queue (QueueDepth entries each) absorb stalls on either side.
// Reset (synchronous, active high): A, X, Y and flags clear, SP goes to 0xFF, queues empty.
`include "eight_bit_cpu_alu_execute_core_defines.svh"
module eight_bit_cpu_alu_execute_core #(
   parameter int unsigned QueueDepth = ebc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ebc_pkg::req_type req_item,
   output logic             full,
   input  logic             pop,
   output ebc_pkg::rsp_type rsp_item,
   output logic             empty
);
   import ebc_pkg::*;

   // Decoded request queue between front and back
   logic    dq_push, dq_full, dq_pop, dq_empty;
   dec_type dq_in, dq_out;

   // Result queue between back end and the response side
   logic    rq_push, rq_full;
   rsp_type rq_in;

   // Front: classify the request and hand it to the decode queue
   ebc_front u_front (
      .push     (push),
      .req_item (req_item),
      .full     (full),
      .dq_push  (dq_push),
      .dq_item  (dq_in),
      .dq_full  (dq_full)
   );

   ebc_fifo #(
      .item_type (dec_type),
      .Depth     (QueueDepth)
   ) u_dec_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (dq_push),
      .push_data (dq_in),
      .full      (dq_full),
      .pop       (dq_pop),
      .pop_data  (dq_out),
      .empty     (dq_empty)
   );

   // Back: execute the oldest decoded request whenever the result queue has room
   ebc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .dq_item  (dq_out),
      .dq_empty (dq_empty),
      .dq_pop   (dq_pop),
      .rq_push  (rq_push),
      .rq_item  (rq_in),
      .rq_full  (rq_full)
   );

   // Hold finished results until the consumer pops them
   ebc_fifo #(
      .item_type (rsp_type),
      .Depth     (QueueDepth)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_data (rq_in),
      .full      (rq_full),
      .pop       (pop),
      .pop_data  (rsp_item),
      .empty     (empty)
   );

   // An accepted request must reach the decode queue
   `EBC_ASSERT_NEXT(a_req_enqueued, push && !full, !dq_empty, "accepted request lost")
   // A retired request must show up on the response side
   `EBC_ASSERT_NEXT(a_rsp_visible, rq_push, !empty, "executed request not visible")
   // Results without a memory write carry zero address and data
   `EBC_ASSERT_IMPLY(a_no_write_zero, !empty && !rsp_item.mem_write,
      rsp_item.write_address == 16'd0 && rsp_item.write_data == 8'd0,
      "stray memory write fields")

endmodule
